// ===== src/texture_tile_4x4_reorder_defines.svh =====
// Assertion macros shared by the tile reorder RTL.
`ifndef TEXTURE_TILE_4X4_REORDER_DEFINES_SVH
`define TEXTURE_TILE_4X4_REORDER_DEFINES_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define TTR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ttr assertion failed");

// Check that cons holds in the cycle after ante.
`define TTR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ttr assertion failed");

// Check that cond holds on every clock edge out of reset.
`define TTR_ASSERT_ALWAYS(lbl, cond) \
  `TTR_ASSERT_IMP(lbl, 1'b1, cond)

`endif

// ===== src/ttr_pkg.sv =====
// Package with the constants and types of the tile reorder block.
package ttr_pkg;

  localparam int MAX_WIDTH = 1024;  // widest image line in pixels
  localparam int PIX_W     = 16;    // pixel width
  localparam int TPR_W     = 9;     // tiles_per_row register width
  localparam int OQ_DEPTH  = 3;     // output queue entries

  // Read request issued to the band store, with its end-of-band mark.
  typedef struct packed {
    logic vld;
    logic last;
  } ttr_rd_t;

endpackage

// ===== src/ttr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ttr_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/ttr_ctrl.sv =====
// Write and read address generation for the ping-pong band store.
`include "texture_tile_4x4_reorder_defines.svh"

module ttr_ctrl #(
  parameter int MaxWidth = ttr_pkg::MAX_WIDTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ttr_pkg::TPR_W-1:0]     cfg_wdata_i,
  input  logic                          acc_i,
  input  logic                          flush_i,
  input  logic [ttr_pkg::PIX_W-1:0]     pixel_i,
  output logic                          wr_en_o,
  output logic [$clog2(MaxWidth)+2:0]   wr_addr_o,
  output logic [ttr_pkg::PIX_W-1:0]     wr_data_o,
  output logic [$clog2(MaxWidth)+2:0]   rd_addr_o,
  output ttr_pkg::ttr_rd_t              rd_o
);
  import ttr_pkg::*;

  localparam int CW   = $clog2(MaxWidth);
  localparam int RiW  = CW + 2;
  localparam int XW   = ((RiW > TPR_W + 4) ? RiW : TPR_W + 4) + 1;
  localparam int TMax = MaxWidth / 4;

  logic [TPR_W-1:0] tpr_q, tpr_d;
  logic [CW-1:0]    wcol_q, wcol_d;
  logic [1:0]       wrow_q, wrow_d;
  logic             whalf_q, whalf_d;
  logic [RiW-1:0]   ridx_q, ridx_d;
  logic             bready_q, bready_d;

  logic             rd_en, rd_last, wr_en, col_wrap;
  logic [CW-1:0]    rd_col;

  // Clamp the register value once, at the write.
  always_comb begin
    tpr_d = tpr_q;
    if (cfg_we_i) begin
      if (cfg_wdata_i == '0) begin
        tpr_d = TPR_W'(1);
      end else if (XW'(cfg_wdata_i) > XW'(TMax)) begin
        tpr_d = TPR_W'(TMax);
      end else begin
        tpr_d = cfg_wdata_i;
      end
    end
  end

  assign rd_en    = acc_i && bready_q;
  assign rd_last  = (XW'(ridx_q) + XW'(1)) >= XW'({tpr_q, 4'b0000});
  assign rd_col   = CW'((ridx_q >> 4) << 2) | CW'(ridx_q[1:0]);
  assign wr_en    = acc_i && !flush_i;
  assign col_wrap = (XW'(wcol_q) + XW'(1)) >= XW'({tpr_q, 2'b00});

  always_comb begin
    wcol_d   = wcol_q;
    wrow_d   = wrow_q;
    whalf_d  = whalf_q;
    ridx_d   = ridx_q;
    bready_d = bready_q;
    // Drain one pixel of the finished band first.
    if (rd_en) begin
      if (rd_last) begin
        bready_d = 1'b0;
        ridx_d   = '0;
      end else begin
        ridx_d = ridx_q + RiW'(1);
      end
    end
    // Then store the incoming pixel; a finished band restarts the drain.
    if (wr_en) begin
      if (col_wrap) begin
        wcol_d = '0;
        if (wrow_q == 2'd3) begin
          wrow_d   = '0;
          whalf_d  = ~whalf_q;
          bready_d = 1'b1;
          ridx_d   = '0;
        end else begin
          wrow_d = wrow_q + 2'd1;
        end
      end else begin
        wcol_d = wcol_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpr_q    <= TPR_W'(1);
      wcol_q   <= '0;
      wrow_q   <= '0;
      whalf_q  <= 1'b0;
      ridx_q   <= '0;
      bready_q <= 1'b0;
    end else begin
      tpr_q    <= tpr_d;
      wcol_q   <= wcol_d;
      wrow_q   <= wrow_d;
      whalf_q  <= whalf_d;
      ridx_q   <= ridx_d;
      bready_q <= bready_d;
    end
  end

  assign wr_en_o   = wr_en;
  assign wr_addr_o = {whalf_q, wrow_q, wcol_q};
  assign wr_data_o = pixel_i;
  assign rd_addr_o = {~whalf_q, ridx_q[3:2], rd_col};
  assign rd_o.vld  = rd_en;
  assign rd_o.last = rd_last;

  `TTR_ASSERT_NXT(a_band_done_sets_ready, wr_en && col_wrap && (wrow_q == 2'd3), bready_q)
  `TTR_ASSERT_IMP(a_read_needs_ready, rd_o.vld, bready_q)
  `TTR_ASSERT_NXT(a_last_clears_ready, rd_en && rd_last && !(wr_en && col_wrap), !bready_q)

endmodule

// ===== src/ttr_oq.sv =====
// Output queue that catches store read data and decouples the receiver.
`include "texture_tile_4x4_reorder_defines.svh"

module ttr_oq #(
  parameter int Depth = ttr_pkg::OQ_DEPTH
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ttr_pkg::ttr_rd_t          issue_i,
  input  logic [ttr_pkg::PIX_W-1:0] rdata_i,
  input  logic                      out_ready_i,
  output logic                      room_o,
  output logic                      out_valid_o,
  output logic [ttr_pkg::PIX_W-1:0] pixel_o,
  output logic                      band_end_o
);
  import ttr_pkg::*;

  localparam int PW   = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  logic [PIX_W:0]  mem_q [Depth];
  logic [PW-1:0]   wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            pend_q, pend_last_q;
  logic            push, pop;

  // One read in flight: its data shows up from the RAM in the next cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= issue_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_last_q <= issue_i.last;
  end

  assign push = pend_q;
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= {pend_last_q, rdata_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= (wptr_q == PW'(Depth - 1)) ? '0 : wptr_q + PW'(1);
      end
      if (pop) begin
        rptr_q <= (rptr_q == PW'(Depth - 1)) ? '0 : rptr_q + PW'(1);
      end
      cnt_q <= cnt_q + CntW'(push) - CntW'(pop);
    end
  end

  // Take a new item only if queued plus in-flight results leave a free slot.
  assign room_o      = (CntW'(cnt_q) + CntW'(pend_q)) <= CntW'(Depth - 1);
  assign out_valid_o = cnt_q != '0;
  assign pixel_o     = mem_q[rptr_q][PIX_W-1:0];
  assign band_end_o  = mem_q[rptr_q][PIX_W];

  `TTR_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CntW'(Depth))
  `TTR_ASSERT_IMP(a_no_overflow, push && (cnt_q == CntW'(Depth)), pop)
  `TTR_ASSERT_IMP(a_issue_has_room, issue_i.vld, room_o)

endmodule

// ===== src/texture_tile_4x4_reorder.sv =====
// Top level: raster-to-4x4-tile pixel reorder with a ping-pong band store.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries pixel_in_i and flush_i. A
//   pixel item is written into the band being filled; each band is four rows
//   of 4*tiles_per_row pixels. Every item (pixel or flush) that arrives while a
//   finished band is pending drains one pixel of it in 4x4 tile order on the
//   output channel (out_valid_o/out_ready_i), with band_end_o on its last one.
//   Items that arrive with no finished band pending give no output item.
//   tiles_per_row_i is written when tiles_per_row_we_i is high; the user must
//   write it only while the block is idle, which the block does not enforce;
//   0 acts as 1 and values above MaxWidth/4 saturate.
// Path: the store read data is registered, then written into the output queue.
// Throughput: one item per cycle while in_ready_o is high, set by the one write and
//   one read port of the band store; reads always go to the finished half and writes
//   to the half being filled, so a read and a write never touch the same entry.
// Reset: counters clear and the block starts filling half zero; the store
//   itself is not cleared and needs no clearing pass.
// Stall: a three-entry output queue holds results while the receiver stalls;
//   in_ready_o drops once queued plus in-flight results fill it.
module texture_tile_4x4_reorder #(
  parameter int MaxWidth = ttr_pkg::MAX_WIDTH
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      tiles_per_row_we_i,
  input  logic [ttr_pkg::TPR_W-1:0] tiles_per_row_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [ttr_pkg::PIX_W-1:0] pixel_in_i,
  input  logic                      flush_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [ttr_pkg::PIX_W-1:0] pixel_out_o,
  output logic                      band_end_o
);
  import ttr_pkg::*;

  // Store address: half, row, column.
  localparam int AW = $clog2(MaxWidth) + 3;

  logic          acc;
  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [PIX_W-1:0] wr_data, rd_data;
  ttr_rd_t       rd;
  logic          room;

  // Accept an item whenever the output queue can take its possible result.
  assign in_ready_o = room;
  assign acc        = in_valid_i && in_ready_o;

  ttr_ctrl #(
    .MaxWidth (MaxWidth)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (tiles_per_row_we_i),
    .cfg_wdata_i (tiles_per_row_i),
    .acc_i       (acc),
    .flush_i     (flush_i),
    .pixel_i     (pixel_in_i),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .rd_addr_o   (rd_addr),
    .rd_o        (rd)
  );

  // Both ping-pong halves share one RAM; the top address bit picks the half.
  ttr_ram #(
    .Width (PIX_W),
    .Depth (2 ** AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd.vld),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  ttr_oq #(
    .Depth (OQ_DEPTH)
  ) u_oq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .issue_i     (rd),
    .rdata_i     (rd_data),
    .out_ready_i (out_ready_i),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .pixel_o     (pixel_out_o),
    .band_end_o  (band_end_o)
  );

endmodule

// ===== test/texture_tile_4x4_reorder_tb.sv =====
// Testbench for the raster-to-4x4-tile pixel reorder: random and directed items, scoreboard check.
module texture_tile_4x4_reorder_tb;
  import ttr_pkg::*;

  localparam int HALF_ENTRIES   = 4 * MAX_WIDTH;  // one band: four rows of the widest line
  localparam int TPR_MAX        = MAX_WIDTH / 4;  // register value where the width saturates
  localparam int FILL_TILES     = 8;              // widest line used below, in tiles
  localparam int PAD_CYCLES     = 6;              // output passes the store read and the queue after its item
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int FLUSH_PCT      = 12;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             band_end;
  } tiled_pixel_t;

  // Tracks the band store and the counters of the block and holds the tile-order
  // pixels still owed by the block, oldest first.
  class tile_order_scoreboard;
    logic [PIX_W-1:0] band_store [2*HALF_ENTRIES];
    int unsigned      col_wr, row_wr, read_idx;
    bit               half_wr, band_pending;
    logic [TPR_W-1:0] tiles_reg;
    tiled_pixel_t     tiled_pixels_q[$];
    int unsigned      errors, pixels_in, flushes_in, results, band_ends, bands_cut;

    function new();
      foreach (band_store[i]) band_store[i] = '0;
      tiles_reg = TPR_W'(1);
    endfunction

    function void set_tiles(logic [TPR_W-1:0] v);
      tiles_reg = v;
    endfunction

    function int unsigned line_width();
      int unsigned t;
      t = tiles_reg;
      if (t < 1) t = 1;
      if (t > TPR_MAX) t = TPR_MAX;
      return 4 * t;
    endfunction

    // Drain one pixel of the finished band first, then store the incoming pixel.
    function void note_input(logic [PIX_W-1:0] pix, logic fl);
      int unsigned  w, row, col, base;
      tiled_pixel_t exp_pix;
      w = line_width();
      if (fl) flushes_in++;
      else pixels_in++;
      if (band_pending) begin
        row  = (read_idx >> 2) & 3;
        col  = 4 * (read_idx >> 4) + (read_idx & 3);
        base = half_wr ? 0 : HALF_ENTRIES;
        exp_pix.pixel    = band_store[base + row * MAX_WIDTH + col];
        exp_pix.band_end = (read_idx + 1 >= 4 * w);
        tiled_pixels_q.push_back(exp_pix);
        if (exp_pix.band_end) begin
          band_pending = 1'b0;
          read_idx     = 0;
        end else begin
          read_idx++;
        end
      end
      if (!fl) begin
        band_store[(half_wr ? HALF_ENTRIES : 0) + row_wr * MAX_WIDTH + col_wr] = pix;
        if (col_wr + 1 >= w) begin
          col_wr = 0;
          if (row_wr >= 3) begin
            // a newer band replaces one that is still draining
            if (band_pending) bands_cut++;
            row_wr       = 0;
            half_wr      = !half_wr;
            band_pending = 1'b1;
            read_idx     = 0;
          end else begin
            row_wr++;
          end
        end else begin
          col_wr++;
        end
      end
    endfunction

    function void check_result(logic [PIX_W-1:0] pix, logic be);
      tiled_pixel_t exp_pix;
      results++;
      if (be === 1'b1) band_ends++;
      if (tiled_pixels_q.size() == 0) begin
        $error("pixel_out %h with band_end %b arrived with nothing expected", pix, be);
        errors++;
        return;
      end
      exp_pix = tiled_pixels_q.pop_front();
      if (pix !== exp_pix.pixel) begin
        $error("pixel_out: expected %h, actual %h", exp_pix.pixel, pix);
        errors++;
      end
      if (be !== exp_pix.band_end) begin
        $error("band_end: expected %b, actual %b", exp_pix.band_end, be);
        errors++;
      end
    endfunction
  endclass

  logic             clk_i              = 1'b0;
  logic             rst_ni             = 1'b0;
  logic             tiles_per_row_we_i = 1'b0;
  logic [TPR_W-1:0] tiles_per_row_i    = '0;
  logic             in_valid_i         = 1'b0;
  logic             in_ready_o;
  logic [PIX_W-1:0] pixel_in_i         = '0;
  logic             flush_i            = 1'b0;
  logic             out_valid_o;
  logic             out_ready_i        = 1'b0;
  logic [PIX_W-1:0] pixel_out_o;
  logic             band_end_o;

  tile_order_scoreboard sb;
  bit                   steady = 1'b0;  // set: neither side inserts gaps
  int unsigned          quiet_cycles = 0;

  texture_tile_4x4_reorder DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .tiles_per_row_we_i (tiles_per_row_we_i),
    .tiles_per_row_i    (tiles_per_row_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .pixel_in_i         (pixel_in_i),
    .flush_i            (flush_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .pixel_out_o        (pixel_out_o),
    .band_end_o         (band_end_o)
  );

  always #5 clk_i = ~clk_i;

  // Draw the idle cycles in front of one item, on either side.
  function automatic int unsigned draw_gap();
    return steady ? 0 : $urandom_range(0, 4);
  endfunction

  // Offer one item and return at the edge that accepts it. Valid stays high
  // afterwards, so the next call either replaces the payload or lowers valid,
  // never both in the same step.
  task automatic send_item(input logic [PIX_W-1:0] pix, input logic fl);
    int unsigned gap;
    gap = draw_gap();
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_in_i <= pix;
    flush_i    <= fl;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_input(pix, fl);
  endtask

  task automatic send_random(input int unsigned n, input int unsigned flush_pct);
    for (int unsigned k = 0; k < n; k++)
      send_item(PIX_W'($urandom), $urandom_range(0, 99) < flush_pct);
  endtask

  // Drop valid, wait for every owed pixel, then let the pipeline settle.
  task automatic wait_results_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.tiled_pixels_q.size() != 0) @(posedge clk_i);
    repeat (PAD_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_tiles_per_row(input logic [TPR_W-1:0] v);
    wait_results_drained();
    @(negedge clk_i);
    tiles_per_row_we_i <= 1'b1;
    tiles_per_row_i    <= v;
    @(posedge clk_i);
    sb.set_tiles(v);
    @(negedge clk_i);
    tiles_per_row_we_i <= 1'b0;
  endtask

  // Flush until the finished band has been read out completely.
  task automatic drain_finished_band();
    while (sb.band_pending) send_item(PIX_W'($urandom), 1'b1);
  endtask

  // Receiver: stall a random number of cycles per item, then take and check it.
  initial begin : receiver
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      stall = draw_gap();
      @(negedge clk_i);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      sb.check_result(pixel_out_o, band_end_o);
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || tiles_per_row_we_i) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned phase_tiles [12];
    int unsigned tiles;
    phase_tiles = '{2, 0, 3, 1, 7, 4, 8, 5, 2, 6, 1, 3};
    sb = new();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Flush with no finished band: no output item.
    send_item(16'hA5A5, 1'b1);
    // One band at the reset width: field extremes and walking ones.
    send_item(16'h0000, 1'b0);
    send_item(16'hFFFF, 1'b0);
    for (int i = 0; i < 14; i++) send_item(PIX_W'(1) << i, 1'b0);
    // Zero acts as one tile; change it while the band waits to drain.
    write_tiles_per_row(TPR_W'(0));
    drain_finished_band();

    // Fill both halves at the widest line used below so every entry that a
    // later read can reach holds data before the width moves around mid-band.
    write_tiles_per_row(TPR_W'(FILL_TILES));
    send_random(2 * 4 * 4 * FILL_TILES, 0);
    drain_finished_band();

    // Grow the width while a band drains: the next band completes first and
    // cuts the older one short.
    write_tiles_per_row(TPR_W'(1));
    send_random(24, 0);
    write_tiles_per_row(TPR_W'(2));
    send_random(16, 0);

    // Random phases; phase lengths do not line up with bands, so widths also
    // change mid-band and mid-drain.
    for (int p = 0; p < 12; p++) begin
      tiles = (p == 10) ? $urandom_range(1, FILL_TILES) : phase_tiles[p];
      write_tiles_per_row(TPR_W'(tiles));
      steady = (p % 4 == 3);
      if (p == 4) begin
        // hold the sender until every owed pixel is out
        send_random(18, FLUSH_PCT);
        wait_results_drained();
        send_random(18, FLUSH_PCT);
      end else begin
        send_random(36, FLUSH_PCT);
      end
    end
    steady = 1'b0;

    drain_finished_band();
    wait_results_drained();

    $display("tb: %0d pixel and %0d flush items in, %0d tile-order pixels checked, %0d band ends",
             sb.pixels_in, sb.flushes_in, sb.results, sb.band_ends);
    $display("tb: line widths 4 to %0d pixels, %0d bands cut short, %0d mismatches",
             4 * FILL_TILES, sb.bands_cut, sb.errors);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/ttr_pkg.sv
src/ttr_ram.sv
src/ttr_ctrl.sv
src/ttr_oq.sv
src/texture_tile_4x4_reorder.sv
test/texture_tile_4x4_reorder_tb.sv
